### rtl/linear_probe_hash_table_assert.svh
// assertion macros for the hash table checker
// needs clk and rst_n in the scope where a macro is used
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LPHT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht assertion failed");

// next-cycle implication, disabled in reset
`define LPHT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht assertion failed");

`endif

### rtl/lpht_pkg.sv
// types and constants of the linear probe hash table
// used by the top level and the checker
package lpht_pkg;

    localparam int SIZE_W    = 11;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam logic [SIZE_W-1:0] COUNT_MAX = 11'd2047;
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;
    localparam logic [SIZE_W-1:0] LOAD_LIMIT_RST = 11'd768;

    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_LOAD_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_FILLED  = 2'd1,
        SLOT_DELETED = 2'd2
    } slot_state_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] value_out;
        logic             load_reached;
    } rsp_t;

    typedef struct packed {
        logic [1:0]       state;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

endpackage

### rtl/linear_probe_hash_table.sv
// top level of the linear probe hash table
// uses lpht_pkg and lpht_ram
//
// Open-addressing hash table with linear probing and tombstones. After reset
// the block sweeps the slot store once before it takes the first item;
// configuration writes are taken throughout. A request item is registered,
// its key is reduced mod table_size in a one-bit-a-step restoring divider,
// then each slot probed takes a ram read and then a compare and write on the
// single ram port, and the result is posted; an unused operation code goes
// straight to posting the result. One item is in work at a time; the next
// item is taken while a finished result still waits.
module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  lpht_pkg::req_t          req,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output lpht_pkg::rsp_t          rsp,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = lpht_pkg::SIZE_W;
    localparam int SLOT_W = $bits(lpht_pkg::slot_t);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         clr_reg;
    logic [SW-1:0]         table_size_reg;
    logic [SW-1:0]         load_limit_reg;
    logic [SW-1:0]         count_reg;
    logic [SW-1:0]         m_reg;
    logic [SW-1:0]         rem_reg;
    logic [SW-1:0]         idx_reg;
    logic [SW-1:0]         probe_reg;
    logic [4:0]            bit_reg;
    logic [31:0]           div_sh_reg;
    logic [1:0]            func_reg;
    logic [31:0]           key_reg;
    logic [31:0]           value_reg;
    logic [1:0]            status_reg;
    logic [31:0]           vout_reg;
    logic                  rsp_valid_reg;
    lpht_pkg::rsp_t        rsp_reg;

    logic [SW-1:0]         m_eff;
    logic [SW:0]           rem_sh;
    logic [SW-1:0]         rem_next;
    logic                  cfg_wr;
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    lpht_pkg::slot_t       ram_wslot;
    logic [SLOT_W-1:0]     ram_rdata;
    lpht_pkg::slot_t       rd;
    logic                  free_slot;
    logic                  key_hit;
    logic                  last_probe;
    logic [SW-1:0]         idx_next;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign prdata    = (paddr[2] == lpht_pkg::REG_LOAD_LIMIT)
                       ? {21'd0, load_limit_reg} : {21'd0, table_size_reg};

    always_comb
    begin
        if (table_size_reg == '0)
        begin
            m_eff = SW'(1);
        end
        else if (32'(table_size_reg) > TABLE_DEPTH)
        begin
            m_eff = SW'(TABLE_DEPTH);
        end
        else
        begin
            m_eff = table_size_reg;
        end
    end

    // one restoring step of key mod m
    assign rem_sh   = {rem_reg, div_sh_reg[31]};
    assign rem_next = (rem_sh >= {1'b0, m_reg}) ? SW'(rem_sh - {1'b0, m_reg})
                                               : SW'(rem_sh);

    assign rd         = lpht_pkg::slot_t'(ram_rdata);
    assign free_slot  = (rd.state != lpht_pkg::SLOT_FILLED);
    assign key_hit    = (rd.state == lpht_pkg::SLOT_FILLED) && (rd.key == key_reg);
    assign last_probe = (probe_reg == m_reg - SW'(1));
    assign idx_next   = (idx_reg == m_reg - SW'(1)) ? '0 : idx_reg + SW'(1);

    always_comb
    begin
        ram_wslot = '0;
        ram_we    = 1'b0;
        ram_addr  = AW'(idx_reg);
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg;
            ram_wslot.state = lpht_pkg::SLOT_EMPTY;
        end
        else if (state_reg == S_EVAL)
        begin
            if (func_reg == lpht_pkg::FUNC_INSERT)
            begin
                ram_we          = free_slot;
                ram_wslot.state = lpht_pkg::SLOT_FILLED;
                ram_wslot.key   = key_reg;
                ram_wslot.value = value_reg;
            end
            else if (func_reg == lpht_pkg::FUNC_DELETE)
            begin
                // keep key and value, mark as tombstone
                ram_we          = key_hit;
                ram_wslot       = rd;
                ram_wslot.state = lpht_pkg::SLOT_DELETED;
            end
        end
    end

    lpht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wslot),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            table_size_reg <= lpht_pkg::TABLE_SIZE_RST;
            load_limit_reg <= lpht_pkg::LOAD_LIMIT_RST;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == lpht_pkg::REG_TABLE_SIZE)
                begin
                    table_size_reg <= pwdata[SW-1:0];
                end
                else
                begin
                    load_limit_reg <= pwdata[SW-1:0];
                end
            end

            // the done state reloads the output register itself
            if (rsp_valid_reg && !rsp_stall && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(TABLE_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        func_reg   <= req.func;
                        key_reg    <= req.key;
                        value_reg  <= req.value;
                        div_sh_reg <= req.key;
                        m_reg      <= m_eff;
                        rem_reg    <= '0;
                        bit_reg    <= '0;
                        probe_reg  <= '0;
                        vout_reg   <= '0;
                        status_reg <= lpht_pkg::ST_NOTFOUND;
                        state_reg  <= (req.func == lpht_pkg::FUNC_NONE) ? S_DONE : S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg    <= rem_next;
                    div_sh_reg <= {div_sh_reg[30:0], 1'b0};
                    bit_reg    <= bit_reg + 5'd1;
                    if (bit_reg == 5'd31)
                    begin
                        idx_reg   <= rem_next;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (func_reg == lpht_pkg::FUNC_INSERT && free_slot)
                    begin
                        status_reg <= lpht_pkg::ST_DONE;
                        if (count_reg != lpht_pkg::COUNT_MAX)
                        begin
                            count_reg <= count_reg + SW'(1);
                        end
                        state_reg <= S_DONE;
                    end
                    else if (func_reg != lpht_pkg::FUNC_INSERT
                             && rd.state == lpht_pkg::SLOT_EMPTY)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (func_reg != lpht_pkg::FUNC_INSERT && key_hit)
                    begin
                        status_reg <= lpht_pkg::ST_DONE;
                        if (func_reg == lpht_pkg::FUNC_LOOKUP)
                        begin
                            vout_reg <= rd.value;
                        end
                        else if (count_reg != '0)
                        begin
                            count_reg <= count_reg - SW'(1);
                        end
                        state_reg <= S_DONE;
                    end
                    else if (last_probe)
                    begin
                        if (func_reg == lpht_pkg::FUNC_INSERT)
                        begin
                            status_reg <= lpht_pkg::ST_FULL;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_next;
                        probe_reg <= probe_reg + SW'(1);
                        state_reg <= S_READ;
                    end
                end
                S_DONE:
                begin
                    // wait for the output register to free up
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg        <= 1'b1;
                        rsp_reg.status       <= status_reg;
                        rsp_reg.value_out    <= vout_reg;
                        rsp_reg.load_reached <= (count_reg >= load_limit_reg);
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/lpht_ram.sv
// generic single-port ram with registered read
// no dependencies
module lpht_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/lpht_checker.sv
// port-level checker for the linear probe hash table, bound to the top level
// uses lpht_pkg and linear_probe_hash_table_assert.svh
`include "linear_probe_hash_table_assert.svh"

module lpht_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input lpht_pkg::rsp_t rsp
);

    // a stalled result stays posted
    `LPHT_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
    // only a successful item carries a value
    `LPHT_ASSERT_IMP(a_vout_zero, rsp_valid && rsp.status != lpht_pkg::ST_DONE, rsp.value_out == '0)
    // status is one of the three codes
    `LPHT_ASSERT_IMP(a_status_code, rsp_valid, rsp.status <= lpht_pkg::ST_FULL)
    // an accepted item keeps the block busy in the next cycle
    `LPHT_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
